[hdl/ppp_pkg.sv]
// Shared types and constants for the programmable parallel port.
// Holds the event, state and result structs and the port C flag positions.
// No dependencies.
package ppp_pkg;

  // Event kinds carried in the input transaction
  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_READ     = 3'd1,
    ACT_STROBE_A = 3'd2,
    ACT_STROBE_B = 3'd3,
    ACT_ACK_A    = 3'd4,
    ACT_ACK_B    = 3'd5
  } ppp_action_t;

  // Register select
  typedef enum logic [1:0] {
    ADDR_PORT_A = 2'd0,
    ADDR_PORT_B = 2'd1,
    ADDR_PORT_C = 2'd2,
    ADDR_CTRL   = 2'd3
  } ppp_addr_t;

  // Reset values
  localparam logic [7:0] CW_RESET = 8'h1B;
  localparam logic [7:0] WM_RESET = 8'hFF;
  localparam logic [7:0] RD_IDLE  = 8'hFF;

  // Port C flag bit positions
  localparam int PC_OBFA  = 7;
  localparam int PC_INTE1 = 6;
  localparam int PC_IBFA  = 5;
  localparam int PC_INTE2 = 4;
  localparam int PC_INTRA = 3;
  localparam int PC_INTEB = 2;
  localparam int PC_BFLAG = 1;
  localparam int PC_INTRB = 0;

  // One input event
  typedef struct packed {
    logic [2:0] action;
    logic [1:0] address;
    logic [7:0] data;
    logic [7:0] pins;
  } ppp_event_t;

  // Architectural state of the port
  typedef struct packed {
    logic [7:0] cw;   // control word
    logic [7:0] la;   // port A output latch
    logic [7:0] lb;   // port B latch
    logic [7:0] lc;   // port C latch
    logic [7:0] sa;   // port A strobed input latch
    logic [7:0] wm;   // port C write mask
    logic [7:0] dm;   // port C drive mask
  } ppp_state_t;

  // One result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       port_a_update;
    logic [7:0] port_a_value;
    logic       port_b_update;
    logic [7:0] port_b_value;
    logic       port_c_update;
    logic [7:0] port_c_value;
  } ppp_result_t;

endpackage

[hdl/ppp_event.sv]
// Event logic of the parallel port: next state and result for one event.
// Purely combinational; uses ppp_pkg types and flag positions.
module ppp_event
  import ppp_pkg::*;
(
  input  ppp_event_t  ev,
  input  ppp_state_t  st,
  output ppp_state_t  st_nxt,
  output ppp_result_t res
);

  // Control word write: clears latches on mode change, rebuilds port C masks
  function automatic ppp_state_t write_control(input ppp_state_t s, input logic [7:0] v);
    ppp_state_t n;
    logic [7:0] diff;
    logic [7:0] dm;
    logic [7:0] wm;
    n    = s;
    diff = s.cw ^ v;
    dm   = 8'h00;
    wm   = 8'h00;
    if (|diff[6:5]) begin
      n.la = 8'h00;
      n.lc = n.lc & 8'h0F;
    end
    if (diff[2]) begin
      n.lb = 8'h00;
      if (|v[6:5]) n.lc = n.lc & 8'hF8;
      else         n.lc = n.lc & 8'hF0;
    end
    n.cw = v;
    // group A
    if (v[6]) begin
      dm[PC_OBFA]  = 1'b1;
      dm[PC_IBFA]  = 1'b1;
      dm[PC_INTRA] = 1'b1;
      wm[PC_INTE1] = 1'b1;
      wm[PC_INTE2] = 1'b1;
    end else if (v[5]) begin
      dm[PC_INTRA] = 1'b1;
      if (v[4]) begin
        dm[PC_IBFA]  = 1'b1;
        wm[PC_INTE2] = 1'b1;
        wm[7:6]      = 2'b11;
        if (!v[3]) dm[7:6] = 2'b11;
      end else begin
        dm[PC_OBFA]  = 1'b1;
        wm[PC_INTE1] = 1'b1;
        wm[5:4]      = 2'b11;
        if (!v[3]) dm[5:4] = 2'b11;
      end
    end else begin
      wm[7:4] = 4'hF;
      if (!v[3]) dm[7:4] = 4'hF;
    end
    // group B; PC3 is free only when group A does not use INTRA
    if (v[2]) begin
      dm[PC_BFLAG] = 1'b1;
      dm[PC_INTRB] = 1'b1;
      wm[PC_INTEB] = 1'b1;
      if (!dm[PC_INTRA] && !v[0]) begin
        dm[3] = 1'b1;
        wm[3] = 1'b1;
      end
    end else if (!v[0]) begin
      dm[2:0] = 3'b111;
      wm[2:0] = 3'b111;
      if (!dm[PC_INTRA]) begin
        dm[3] = 1'b1;
        wm[3] = 1'b1;
      end
    end
    n.dm = dm;
    n.wm = wm;
    return n;
  endfunction

  logic [7:0] cw;
  logic [7:0] rd;
  logic [7:0] bsr_bit;
  logic       ua, ub, uc;
  ppp_state_t ns;

  assign cw      = st.cw;
  assign bsr_bit = 8'h01 << ev.data[3:1];

  // Event decode
  always_comb begin
    ns = st;
    rd = RD_IDLE;
    ua = 1'b0;
    ub = 1'b0;
    uc = 1'b0;
    case (ev.action)
      ACT_WRITE: begin
        case (ev.address)
          ADDR_PORT_A: begin
            ns.la = ev.data;
            if (cw[6] || !cw[4]) begin
              if (|cw[6:5]) begin
                ns.lc[PC_OBFA] = 1'b0;
                if (cw[6:5] == 2'b01 || !ns.lc[PC_IBFA]) ns.lc[PC_INTRA] = 1'b0;
                uc = 1'b1;
              end
              if (!cw[6]) ua = 1'b1;
            end
          end
          ADDR_PORT_B: begin
            if (!cw[1]) begin
              ns.lb = ev.data;
              if (cw[2]) begin
                ns.lc[PC_BFLAG] = 1'b0;
                ns.lc[PC_INTRB] = 1'b0;
                uc = 1'b1;
              end
              ub = 1'b1;
            end
          end
          ADDR_PORT_C: begin
            ns.lc = (st.lc & ~st.wm) | (ev.data & st.wm);
            if (|st.dm) uc = 1'b1;
          end
          ADDR_CTRL: begin
            if (ev.data[7]) begin
              ns = write_control(st, ev.data);
            end else if (|(st.wm & bsr_bit)) begin
              // bit set/reset on one port C bit
              if (ev.data[0]) ns.lc = st.lc | bsr_bit;
              else            ns.lc = st.lc & ~bsr_bit;
              if (|st.dm) uc = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        case (ev.address)
          ADDR_PORT_A: begin
            if (|cw[6:5]) begin
              if (cw[6] || cw[4]) begin
                ns.lc[PC_IBFA] = 1'b0;
                if (!cw[6] || ns.lc[PC_OBFA]) ns.lc[PC_INTRA] = 1'b0;
                uc = 1'b1;
              end
              rd = st.sa;
            end else if (cw[4]) begin
              rd = ev.pins;
            end else begin
              rd = st.la;
            end
          end
          ADDR_PORT_B: begin
            if (cw[2]) begin
              if (cw[1]) begin
                ns.lc[PC_BFLAG] = 1'b0;
                ns.lc[PC_INTRB] = 1'b0;
                uc = 1'b1;
              end
              rd = st.lb;
            end else if (cw[1]) begin
              rd = ev.pins;
            end else begin
              rd = st.lb;
            end
          end
          ADDR_PORT_C: rd = st.lc;
          default:     rd = RD_IDLE;
        endcase
      end
      ACT_STROBE_A: begin
        if (cw[6:4] == 3'b011 || cw[6]) begin
          ns.sa          = ev.data;
          ns.lc[PC_IBFA] = 1'b1;
          if (st.lc[PC_INTE2]) ns.lc[PC_INTRA] = 1'b1;
          uc = 1'b1;
        end
      end
      ACT_STROBE_B: begin
        if (cw[2:1] == 2'b11) begin
          ns.lb           = ev.data;
          ns.lc[PC_BFLAG] = 1'b1;
          if (st.lc[PC_INTEB]) ns.lc[PC_INTRB] = 1'b1;
          uc = 1'b1;
        end
      end
      ACT_ACK_A: begin
        if (cw[6:4] == 3'b010 || cw[6]) begin
          ns.lc[PC_OBFA] = 1'b1;
          if (st.lc[PC_INTE1]) ns.lc[PC_INTRA] = 1'b1;
          uc = 1'b1;
          rd = st.la;
        end else if (!cw[4]) begin
          rd = st.la;
        end
      end
      ACT_ACK_B: begin
        if (cw[2:1] == 2'b10) begin
          ns.lc[PC_BFLAG] = 1'b1;
          if (st.lc[PC_INTEB]) ns.lc[PC_INTRB] = 1'b1;
          uc = 1'b1;
          rd = st.lb;
        end else if (!cw[1]) begin
          rd = st.lb;
        end
      end
      default: ;
    endcase
  end

  assign st_nxt = ns;

  // Result item, taken from the state after the event
  always_comb begin
    res.read_data     = rd;
    res.port_a_update = ua;
    res.port_a_value  = ns.la;
    res.port_b_update = ub;
    res.port_b_value  = ns.lb;
    res.port_c_update = uc;
    res.port_c_value  = ns.lc & ns.dm;
  end

endmodule

[hdl/programmable_parallel_port.sv]
// Top level of the programmable parallel port: stream ports, input and result
// registers, port state. Depends on ppp_pkg and ppp_event.
//
// Each input transaction is one event (bus write, bus read, strobe A/B or
// acknowledge A/B) and yields exactly one result transaction holding the read
// data and the values driven on ports A, B and C. The block sustains one event
// per clock when the output is not stalled: an event is held in the input
// register, is decoded against the port state by a single level of masking
// logic and lands in the result register. The port state is updated in the
// same edge the result is loaded, so back-to-back events see each other in
// order. Back-pressure on the output stalls both stages.
module programmable_parallel_port
  import ppp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data, [15:8] pins_in
  input  logic [4:0]  in_tuser,   // [2:0] action, [4:3] address
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [7:0] read_data, [8] port_a_update,
                                  // [16:9] port_a_value, [17] port_b_update,
                                  // [25:18] port_b_value, [26] port_c_update,
                                  // [34:27] port_c_value, [39:35] zero
);

  logic        s1_valid_r, s1_valid_nxt;
  ppp_event_t  s1_ev_r;
  logic        out_valid_r, out_valid_nxt;
  ppp_result_t out_res_r;
  ppp_state_t  st_r, st_nxt;
  ppp_result_t res;
  logic        adv;

  // Stage 2 moves when the result register is free or being drained
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;

  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  // Event logic
  ppp_event u_event (
    .ev     (s1_ev_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Control and port state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.cw     <= CW_RESET;
      st_r.la     <= 8'h00;
      st_r.lb     <= 8'h00;
      st_r.lc     <= 8'h00;
      st_r.sa     <= 8'h00;
      st_r.wm     <= WM_RESET;
      st_r.dm     <= 8'h00;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv && s1_valid_r) st_r <= st_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ev_r.action  <= in_tuser[2:0];
      s1_ev_r.address <= in_tuser[4:3];
      s1_ev_r.data    <= in_tdata[7:0];
      s1_ev_r.pins    <= in_tdata[15:8];
    end
    if (adv && s1_valid_r) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000,
                       out_res_r.port_c_value, out_res_r.port_c_update,
                       out_res_r.port_b_value, out_res_r.port_b_update,
                       out_res_r.port_a_value, out_res_r.port_a_update,
                       out_res_r.read_data};

  // A held result always matches the state it left behind
  a_res_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.port_a_value == st_r.la) &&
                    (out_res_r.port_b_value == st_r.lb) &&
                    (out_res_r.port_c_value == (st_r.lc & st_r.dm)))
    else $error("result register out of step with port state");

  // Port state only changes when a result is loaded
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && s1_valid_r) |=> $stable(st_r))
    else $error("port state changed without an event");

  // A stalled event in the input register is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r && $stable(s1_ev_r))
    else $error("stalled event dropped");

endmodule

[tb/tb_programmable_parallel_port.sv]
// Self-checking testbench for the programmable parallel port.
// Drives directed and random events, predicts each result, checks every field.
// Depends on ppp_pkg and the programmable_parallel_port top level.
module tb_programmable_parallel_port;
  import ppp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes the block treats as no-ops
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;

  // Control words used by the directed tests
  localparam logic [7:0] CW_ALL_OUT = 8'h80;  // mode 0, all ports output
  localparam logic [7:0] CW_M1_IN   = 8'hB6;  // A mode 1 in, B mode 1 in
  localparam logic [7:0] CW_M1_OUT  = 8'hA4;  // A mode 1 out, B mode 1 out
  localparam logic [7:0] CW_M2      = 8'hC0;  // A mode 2, B mode 0 out

  localparam int MAX_GAP = 13;
  localparam int RANDOM_ITEMS = 780;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] data, [15:8] pins_in
  logic [4:0]  in_tuser;   // [2:0] action, [4:3] address
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [7:0] read_data, [8] a_update, [16:9] a_value,
                           // [17] b_update, [25:18] b_value, [26] c_update,
                           // [34:27] c_value, [39:35] zero

  ppp_state_t  port_state;
  ppp_result_t expected_results[$];
  int          error_count = 0;
  int          sent_count = 0;
  bit          burst_mode = 1'b0;

  programmable_parallel_port i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Predict one event: update the port state and return the result
  function automatic ppp_result_t port_model_step(input ppp_event_t ev);
    ppp_result_t r;
    logic [7:0]  cw;
    logic [7:0]  diff;
    logic [7:0]  bitm;
    logic [7:0]  dmask;
    logic [7:0]  wmask;
    cw = port_state.cw;
    r = '0;
    r.read_data = RD_IDLE;
    case (ev.action)
      ACT_WRITE: begin
        case (ev.address)
          ADDR_PORT_A: begin
            port_state.la = ev.data;
            if (cw[6] || !cw[4]) begin
              if (cw[6] || cw[5]) begin
                port_state.lc[PC_OBFA] = 1'b0;
                if ((cw & 8'h60) == 8'h20 || !port_state.lc[PC_IBFA])
                  port_state.lc[PC_INTRA] = 1'b0;
                r.port_c_update = 1'b1;
              end
              if (!cw[6]) r.port_a_update = 1'b1;
            end
          end
          ADDR_PORT_B: begin
            if (!cw[1]) begin
              port_state.lb = ev.data;
              if (cw[2]) begin
                port_state.lc[PC_BFLAG] = 1'b0;
                port_state.lc[PC_INTRB] = 1'b0;
                r.port_c_update = 1'b1;
              end
              r.port_b_update = 1'b1;
            end
          end
          ADDR_PORT_C: begin
            port_state.lc = (port_state.lc & ~port_state.wm) | (ev.data & port_state.wm);
            if (port_state.dm != 8'h00) r.port_c_update = 1'b1;
          end
          default: begin
            if (ev.data[7]) begin
              // Mode change: clear the latches of the groups that moved
              diff = cw ^ ev.data;
              if (diff[6] || diff[5]) begin
                port_state.la = 8'h00;
                port_state.lc &= 8'h0F;
              end
              if (diff[2]) begin
                port_state.lb = 8'h00;
                if (ev.data[6] || ev.data[5]) port_state.lc &= 8'hF8;
                else port_state.lc &= 8'hF0;
              end
              port_state.cw = ev.data;
              dmask = 8'h00;
              wmask = 8'h00;
              // Group A: port C upper half
              if (ev.data[6]) begin
                dmask[PC_OBFA] = 1'b1;
                dmask[PC_IBFA] = 1'b1;
                dmask[PC_INTRA] = 1'b1;
                wmask[PC_INTE1] = 1'b1;
                wmask[PC_INTE2] = 1'b1;
              end else if (ev.data[5]) begin
                dmask[PC_INTRA] = 1'b1;
                if (ev.data[4]) begin
                  dmask[PC_IBFA] = 1'b1;
                  wmask[PC_INTE2] = 1'b1;
                  wmask |= 8'hC0;
                  if (!ev.data[3]) dmask |= 8'hC0;
                end else begin
                  dmask[PC_OBFA] = 1'b1;
                  wmask[PC_INTE1] = 1'b1;
                  wmask |= 8'h30;
                  if (!ev.data[3]) dmask |= 8'h30;
                end
              end else begin
                wmask |= 8'hF0;
                if (!ev.data[3]) dmask |= 8'hF0;
              end
              // Group B: port C lower half, PC3 shared with INTRA
              if (ev.data[2]) begin
                dmask[PC_BFLAG] = 1'b1;
                dmask[PC_INTRB] = 1'b1;
                wmask[PC_INTEB] = 1'b1;
                if (!dmask[PC_INTRA] && !ev.data[0]) begin
                  dmask[PC_INTRA] = 1'b1;
                  wmask[PC_INTRA] = 1'b1;
                end
              end else if (!ev.data[0]) begin
                dmask |= 8'h07;
                wmask |= 8'h07;
                if (!dmask[PC_INTRA]) begin
                  dmask[PC_INTRA] = 1'b1;
                  wmask[PC_INTRA] = 1'b1;
                end
              end
              port_state.dm = dmask;
              port_state.wm = wmask;
            end else begin
              // Single bit set/reset on port C
              bitm = 8'h01 << ev.data[3:1];
              if ((port_state.wm & bitm) != 8'h00) begin
                if (ev.data[0]) port_state.lc |= bitm;
                else port_state.lc &= ~bitm;
                if (port_state.dm != 8'h00) r.port_c_update = 1'b1;
              end
            end
          end
        endcase
      end
      ACT_READ: begin
        case (ev.address)
          ADDR_PORT_A: begin
            if (cw[6] || cw[5]) begin
              if ((cw & 8'h50) != 8'h00) begin
                port_state.lc[PC_IBFA] = 1'b0;
                if (!cw[6] || port_state.lc[PC_OBFA]) port_state.lc[PC_INTRA] = 1'b0;
                r.port_c_update = 1'b1;
              end
              r.read_data = port_state.sa;
            end else if (cw[4]) begin
              r.read_data = ev.pins;
            end else begin
              r.read_data = port_state.la;
            end
          end
          ADDR_PORT_B: begin
            if (cw[2]) begin
              if (cw[1]) begin
                port_state.lc[PC_BFLAG] = 1'b0;
                port_state.lc[PC_INTRB] = 1'b0;
                r.port_c_update = 1'b1;
              end
              r.read_data = port_state.lb;
            end else if (cw[1]) begin
              r.read_data = ev.pins;
            end else begin
              r.read_data = port_state.lb;
            end
          end
          ADDR_PORT_C: r.read_data = port_state.lc;
          default: ;
        endcase
      end
      ACT_STROBE_A: begin
        if ((cw & 8'h70) == 8'h30 || cw[6]) begin
          port_state.sa = ev.data;
          port_state.lc[PC_IBFA] = 1'b1;
          if (port_state.lc[PC_INTE2]) port_state.lc[PC_INTRA] = 1'b1;
          r.port_c_update = 1'b1;
        end
      end
      ACT_STROBE_B: begin
        if ((cw & 8'h06) == 8'h06) begin
          port_state.lb = ev.data;
          port_state.lc[PC_BFLAG] = 1'b1;
          if (port_state.lc[PC_INTEB]) port_state.lc[PC_INTRB] = 1'b1;
          r.port_c_update = 1'b1;
        end
      end
      ACT_ACK_A: begin
        if ((cw & 8'h70) == 8'h20 || cw[6]) begin
          port_state.lc[PC_OBFA] = 1'b1;
          if (port_state.lc[PC_INTE1]) port_state.lc[PC_INTRA] = 1'b1;
          r.port_c_update = 1'b1;
          r.read_data = port_state.la;
        end else if (!cw[4]) begin
          r.read_data = port_state.la;
        end
      end
      ACT_ACK_B: begin
        if ((cw & 8'h06) == 8'h04) begin
          port_state.lc[PC_BFLAG] = 1'b1;
          if (port_state.lc[PC_INTEB]) port_state.lc[PC_INTRB] = 1'b1;
          r.port_c_update = 1'b1;
          r.read_data = port_state.lb;
        end else if (!cw[1]) begin
          r.read_data = port_state.lb;
        end
      end
      default: ;
    endcase
    r.port_a_value = port_state.la;
    r.port_b_value = port_state.lb;
    r.port_c_value = port_state.lc & port_state.dm;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Bit set/reset command byte for port C
  function automatic logic [7:0] bsr_cmd(input int bit_idx, input bit set_bit);
    logic [2:0] idx;
    idx = bit_idx[2:0];
    return {4'b0000, idx, set_bit};
  endfunction

  // Prediction on input transactions, checking on result transactions
  always @(posedge clk) begin
    ppp_event_t  ev;
    ppp_result_t exp_r;
    if (rst_n && in_tvalid && in_tready) begin
      ev.action  = in_tuser[2:0];
      ev.address = in_tuser[4:3];
      ev.data    = in_tdata[7:0];
      ev.pins    = in_tdata[15:8];
      expected_results.push_back(port_model_step(ev));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %010h", $time, out_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("read_data", exp_r.read_data, out_tdata[7:0]);
        check_field("port_a_update", {7'd0, exp_r.port_a_update}, {7'd0, out_tdata[8]});
        check_field("port_a_value", exp_r.port_a_value, out_tdata[16:9]);
        check_field("port_b_update", {7'd0, exp_r.port_b_update}, {7'd0, out_tdata[17]});
        check_field("port_b_value", exp_r.port_b_value, out_tdata[25:18]);
        check_field("port_c_update", {7'd0, exp_r.port_c_update}, {7'd0, out_tdata[26]});
        check_field("port_c_value", exp_r.port_c_value, out_tdata[34:27]);
        check_field("pad", 8'h00, {3'd0, out_tdata[39:35]});
      end
    end
  end

  // Result sink with random stalls
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Send one event; starts and ends at a falling edge, tvalid left high
  task automatic send_event(input logic [2:0] act, input logic [1:0] addr,
                            input logic [7:0] dat, input logic [7:0] pins);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {pins, dat};
    in_tuser  = {addr, act};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent_count++;
  endtask

  // Stop sending until every expected result has come back
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_event(ACT_READ, ADDR_CTRL, 8'h00, 8'hFF);
    send_event(ACT_READ, ADDR_PORT_A, 8'hFF, 8'hA5);
    send_event(ACT_READ, ADDR_PORT_B, 8'h00, 8'h5A);
    send_event(ACT_READ, ADDR_PORT_C, 8'h00, 8'h00);
  endtask

  task automatic test_ignored_events();
    send_event(ACT_RSVD_6, ADDR_PORT_A, 8'hFF, 8'hFF);
    send_event(ACT_RSVD_7, ADDR_CTRL, 8'h80, 8'h00);
    send_event(ACT_WRITE, ADDR_PORT_B, 8'hFF, 8'h00);
    send_event(ACT_ACK_A, ADDR_PORT_A, 8'h00, 8'h00);
    send_event(ACT_STROBE_A, ADDR_PORT_A, 8'h77, 8'h00);
    send_event(ACT_STROBE_B, ADDR_PORT_B, 8'h77, 8'h00);
  endtask

  task automatic test_mode0_output();
    send_event(ACT_WRITE, ADDR_CTRL, CW_ALL_OUT, 8'h00);
    send_event(ACT_WRITE, ADDR_PORT_A, 8'hFF, 8'h00);
    send_event(ACT_WRITE, ADDR_PORT_B, 8'h00, 8'hFF);
    send_event(ACT_WRITE, ADDR_PORT_C, 8'hFF, 8'h00);
    send_event(ACT_WRITE, ADDR_CTRL, bsr_cmd(0, 1'b0), 8'h00);
    send_event(ACT_ACK_B, ADDR_PORT_B, 8'h00, 8'h00);
    send_event(ACT_READ, ADDR_PORT_C, 8'h00, 8'h00);
  endtask

  task automatic test_mode1_input();
    send_event(ACT_WRITE, ADDR_CTRL, CW_M1_IN, 8'h00);
    send_event(ACT_WRITE, ADDR_CTRL, bsr_cmd(PC_INTE2, 1'b1), 8'h00);
    send_event(ACT_WRITE, ADDR_CTRL, bsr_cmd(PC_IBFA, 1'b1), 8'h00);  // outside mask
    send_event(ACT_STROBE_A, ADDR_PORT_A, 8'hA5, 8'h00);
    send_event(ACT_READ, ADDR_PORT_A, 8'h00, 8'h00);
    send_event(ACT_WRITE, ADDR_CTRL, bsr_cmd(PC_INTEB, 1'b1), 8'h00);
    send_event(ACT_STROBE_B, ADDR_PORT_B, 8'h5A, 8'h00);
    send_event(ACT_READ, ADDR_PORT_B, 8'h00, 8'h00);
  endtask

  task automatic test_mode1_output();
    send_event(ACT_WRITE, ADDR_CTRL, CW_M1_OUT, 8'h00);
    send_event(ACT_WRITE, ADDR_CTRL, bsr_cmd(PC_INTE1, 1'b1), 8'h00);
    send_event(ACT_WRITE, ADDR_PORT_A, 8'h3C, 8'h00);
    send_event(ACT_ACK_A, ADDR_PORT_A, 8'h00, 8'h00);
    send_event(ACT_WRITE, ADDR_PORT_B, 8'hC3, 8'h00);
    send_event(ACT_ACK_B, ADDR_PORT_B, 8'h00, 8'h00);
  endtask

  task automatic test_mode2();
    send_event(ACT_WRITE, ADDR_CTRL, CW_M2, 8'h00);
    send_event(ACT_STROBE_A, ADDR_PORT_A, 8'h96, 8'h00);
    send_event(ACT_WRITE, ADDR_PORT_A, 8'h69, 8'h00);
    send_event(ACT_ACK_A, ADDR_PORT_A, 8'h00, 8'h00);
    send_event(ACT_READ, ADDR_PORT_A, 8'h00, 8'h00);
  endtask

  // Rounds of: new mode, port C bit set/reset commands, then handshake-heavy traffic
  task automatic test_random_traffic();
    int start_count;
    int rounds;
    int n;
    int pick;
    logic [2:0] act;
    logic [1:0] addr;
    logic [7:0] dat;
    start_count = sent_count;
    rounds = 0;
    while (sent_count - start_count < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      send_event(ACT_WRITE, ADDR_CTRL, 8'h80 | 8'($urandom_range(0, 127)), 8'($urandom));
      n = $urandom_range(1, 4);
      repeat (n) begin
        send_event(ACT_WRITE, ADDR_CTRL, bsr_cmd($urandom_range(0, 7),
                   $urandom_range(0, 3) != 0), 8'($urandom));
      end
      n = $urandom_range(10, 30);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        addr = 2'($urandom_range(0, 3));
        dat  = 8'($urandom);
        if (pick < 20) begin
          act = ACT_WRITE;
          if (addr == ADDR_CTRL && $urandom_range(0, 4) != 0) dat[7] = 1'b0;
        end else if (pick < 45) begin
          act = ACT_READ;
        end else if (pick < 60) begin
          act = ($urandom_range(0, 1) != 0) ? ACT_STROBE_A : ACT_STROBE_B;
        end else if (pick < 80) begin
          act = ($urandom_range(0, 1) != 0) ? ACT_ACK_A : ACT_ACK_B;
        end else begin
          act = 3'($urandom_range(0, 7));
        end
        send_event(act, addr, dat, 8'($urandom));
      end
      rounds++;
      if (rounds % 6 == 0) drain_results();
    end
    burst_mode = 1'b0;
  endtask

  // Main sequence
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    port_state = '{cw: CW_RESET, la: 8'h00, lb: 8'h00, lc: 8'h00, sa: 8'h00,
                   wm: WM_RESET, dm: 8'h00};
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_ignored_events();
    test_mode0_output();
    test_mode1_input();
    burst_mode = 1'b1;
    test_mode1_output();
    burst_mode = 1'b0;
    test_mode2();
    drain_results();
    test_random_traffic();
    drain_results();
    repeat (8) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_programmable_parallel_port passed");
    end else begin
      $display("tb_programmable_parallel_port failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("tb_programmable_parallel_port failed");
    $finish;
  end

endmodule
